FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define CHK_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CHK_IMPLY(lbl, clk, rst_n, pre, post, msg)
`define CHK_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/mch_pkg.sv
`timescale 1ns / 1ps
// constants, tables and types of the calibrated heading block
// no dependencies
package mch_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN = 24;
    localparam int STEP_COUNT = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int DIV_STEPS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BACK_LAT = DIV_STEPS + 2 * STEP_COUNT + 6;
    localparam int ROT_W = 34;
    localparam int VEC_W = 36;

    localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [ROT_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [15:0] HEADING_SCALE = 16'sd23040;
    localparam logic signed [18:0] HALF_TURN_LIMIT = 19'sd11520;

    localparam logic [29:0] ARC_TABLE [TABLE_LEN] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10680350, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
        30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81
    };

    typedef enum logic [2:0] {
        REG_X_LOW  = 3'd0,
        REG_X_HIGH = 3'd1,
        REG_Y_LOW  = 3'd2,
        REG_Y_HIGH = 3'd3,
        REG_Z_LOW  = 3'd4,
        REG_Z_HIGH = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [2:0][15:0]   num;
        logic [2:0][15:0]   den;
        logic [2:0]         zero;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } front_item_t;

endpackage

FILE: rtl/mch_if.sv
`timescale 1ns / 1ps
// handshake channels: sample in, result out, configuration write
// no dependencies
interface mch_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    modport source (output valid, raw_x, raw_y, raw_z, roll_angle, pitch_angle, input ready);
    modport sink (input valid, raw_x, raw_y, raw_z, roll_angle, pitch_angle, output ready);
endinterface

interface mch_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [14:0] heading_angle;
    logic               range_error;
    modport source (output valid, norm_x, norm_y, norm_z, heading_angle, range_error,
                    input ready);
    modport sink (input valid, norm_x, norm_y, norm_z, heading_angle, range_error,
                  output ready);
endinterface

interface mch_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/mch_front.sv
`timescale 1ns / 1ps
// front part: limit registers, clamp and division operands per axis
// depends on mch_pkg and mch_if
module mch_front (
    input  logic                clk,
    input  logic                rst_n,
    mch_cfg_if.sink             cfg,
    mch_sample_if.sink          sample,
    input  logic                q_ready,
    output logic                push,
    output mch_pkg::front_item_t item
);

    localparam logic signed [15:0] LOW_RESET [3] = '{-16'sd720, -16'sd775, -16'sd37};
    localparam logic signed [15:0] HIGH_RESET [3] = '{16'sd380, 16'sd145, 16'sd1035};

    logic signed [15:0] lo_reg [3];
    logic signed [15:0] hi_reg [3];
    logic signed [15:0] raw [3];

    assign cfg.ready = 1'b1;
    assign sample.ready = q_ready;
    assign push = sample.valid && q_ready;

    assign raw[0] = sample.raw_x;
    assign raw[1] = sample.raw_y;
    assign raw[2] = sample.raw_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= LOW_RESET[a];
                hi_reg[a] <= HIGH_RESET[a];
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mch_pkg::REG_X_LOW:  lo_reg[0] <= cfg.data;
                mch_pkg::REG_X_HIGH: hi_reg[0] <= cfg.data;
                mch_pkg::REG_Y_LOW:  lo_reg[1] <= cfg.data;
                mch_pkg::REG_Y_HIGH: hi_reg[1] <= cfg.data;
                mch_pkg::REG_Z_LOW:  lo_reg[2] <= cfg.data;
                mch_pkg::REG_Z_HIGH: hi_reg[2] <= cfg.data;
                default: ;
            endcase
        end
    end

    // clamp to the window, offset from low limit, span as divisor
    always_comb
    begin
        logic signed [15:0] v_hi;
        logic signed [15:0] v_cl;
        logic signed [16:0] diff;
        logic signed [16:0] span;
        for (int a = 0; a < 3; a++)
        begin
            v_hi = (raw[a] < hi_reg[a]) ? raw[a] : hi_reg[a];
            v_cl = (v_hi > lo_reg[a]) ? v_hi : lo_reg[a];
            diff = {v_cl[15], v_cl} - {lo_reg[a][15], lo_reg[a]};
            span = {hi_reg[a][15], hi_reg[a]} - {lo_reg[a][15], lo_reg[a]};
            item.num[a] = diff[15:0];
            item.den[a] = (span > 17'sd0) ? span[15:0] : 16'd1;
            item.zero[a] = (lo_reg[a] == hi_reg[a]);
        end
        item.roll = sample.roll_angle;
        item.pitch = sample.pitch_angle;
    end

endmodule

FILE: rtl/mch_queue.sv
`timescale 1ns / 1ps
// short item queue between front and back
// depends on mch_pkg
module mch_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mch_pkg::front_item_t wr_item,
    output logic                full,
    input  logic                pop,
    output logic                head_vld,
    output mch_pkg::front_item_t head
);

    mch_pkg::front_item_t mem_reg [mch_pkg::QUEUE_DEPTH];
    logic [mch_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mch_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mch_pkg::QCNT_W-1:0] cnt_reg;

    assign full = (cnt_reg == mch_pkg::QCNT_W'(mch_pkg::QUEUE_DEPTH));
    assign head_vld = (cnt_reg != '0);
    assign head = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mch_sincos.sv
`timescale 1ns / 1ps
// pipelined rotation cordic giving q1.15 sine and cosine of a binary angle
// depends on mch_pkg
module mch_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output logic signed [15:0] sin_q15,
    output logic signed [15:0] cos_q15
);

    localparam int SC = mch_pkg::STEP_COUNT;
    localparam int RW = mch_pkg::ROT_W;

    logic signed [RW-1:0] x_reg [SC];
    logic signed [RW-1:0] y_reg [SC];
    logic signed [RW-1:0] z_reg [SC];
    logic                 neg_reg [SC];
    logic signed [15:0]   sin_reg;
    logic signed [15:0]   cos_reg;
    logic signed [RW-1:0] z_fold;
    logic                 neg_fold;

    function automatic logic signed [15:0] to_q15(input logic signed [RW-1:0] v,
                                                  input logic neg);
        logic signed [RW-1:0] t;
        logic signed [RW-15:0] r;
        t = v + RW'(16384);
        r = {t[RW-1], t[RW-1:15]};
        if (neg)
        begin
            r = -r;
        end
        if (r > 20'sd32767)
        begin
            r = 20'sd32767;
        end
        else if (r < -20'sd32768)
        begin
            r = -20'sd32768;
        end
        return r[15:0];
    endfunction

    // fold into the right half plane
    always_comb
    begin
        logic signed [16:0] ae;
        logic signed [16:0] af;
        ae = {angle[15], angle};
        neg_fold = 1'b0;
        af = ae;
        if (ae > 17'sd16384)
        begin
            af = ae - 17'sd32768;
            neg_fold = 1'b1;
        end
        else if (ae < -17'sd16384)
        begin
            af = ae + 17'sd32768;
            neg_fold = 1'b1;
        end
        z_fold = RW'($signed({af, 16'd0}));
    end

    for (genvar i = 0; i < SC; i++)
    begin : g_step
        localparam logic signed [RW-1:0] ARC = $signed({{(RW - 30){1'b0}},
                                                        mch_pkg::ARC_TABLE[i]});
        logic signed [RW-1:0] x_in;
        logic signed [RW-1:0] y_in;
        logic signed [RW-1:0] z_in;
        logic                 neg_in;
        if (i == 0)
        begin : g_first
            assign x_in = mch_pkg::INV_GAIN_Q30;
            assign y_in = '0;
            assign z_in = z_fold;
            assign neg_in = neg_fold;
        end
        else
        begin : g_next
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_in >= 0)
                begin
                    x_reg[i] <= x_in - (y_in >>> i);
                    y_reg[i] <= y_in + (x_in >>> i);
                    z_reg[i] <= z_in - ARC;
                end
                else
                begin
                    x_reg[i] <= x_in + (y_in >>> i);
                    y_reg[i] <= y_in - (x_in >>> i);
                    z_reg[i] <= z_in + ARC;
                end
                neg_reg[i] <= neg_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= to_q15(y_reg[SC-1], neg_reg[SC-1]);
            cos_reg <= to_q15(x_reg[SC-1], neg_reg[SC-1]);
        end
    end

    assign sin_q15 = sin_reg;
    assign cos_q15 = cos_reg;

endmodule

FILE: rtl/mch_back.sv
`timescale 1ns / 1ps
// back part: axis division, tilt terms, vectoring cordic, output register
// depends on mch_pkg, mch_if and mch_sincos
module mch_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_vld,
    input  mch_pkg::front_item_t head,
    output logic                pop,
    mch_result_if.source        result
);

    localparam int SC = mch_pkg::STEP_COUNT;
    localparam int DS = mch_pkg::DIV_STEPS;
    localparam int LAT = mch_pkg::BACK_LAT;
    localparam int RW = mch_pkg::ROT_W;
    localparam int VW = mch_pkg::VEC_W;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic           res_vld_reg;

    assign en = !res_vld_reg || result.ready;
    assign pop = en && head_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], head_vld};
            res_vld_reg <= vld_reg[LAT-1];
        end
    end

    // restoring division, one quotient bit per stage
    logic [31:0]        drem_reg [DS][3];
    logic [15:0]        dq_reg [DS][3];
    logic [15:0]        dden_reg [DS][3];
    logic [2:0]         dzero_reg [DS];
    logic signed [15:0] droll_reg [DS];
    logic signed [15:0] dpitch_reg [DS];

    for (genvar s = 0; s < DS; s++)
    begin : g_div
        logic [31:0]        rem_in [3];
        logic [15:0]        q_in [3];
        logic [15:0]        den_in [3];
        logic [2:0]         zero_in;
        logic signed [15:0] roll_in;
        logic signed [15:0] pitch_in;
        logic [31:0]        rem_nx [3];
        logic [15:0]        q_nx [3];
        if (s == 0)
        begin : g_first
            always_comb
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rem_in[a] = {head.num[a], 16'd0} - {16'd0, head.num[a]};
                    q_in[a] = '0;
                    den_in[a] = head.den[a];
                end
                zero_in = head.zero;
                roll_in = head.roll;
                pitch_in = head.pitch;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rem_in[a] = drem_reg[s-1][a];
                    q_in[a] = dq_reg[s-1][a];
                    den_in[a] = dden_reg[s-1][a];
                end
                zero_in = dzero_reg[s-1];
                roll_in = droll_reg[s-1];
                pitch_in = dpitch_reg[s-1];
            end
        end
        always_comb
        begin
            logic [31:0] dsh;
            for (int a = 0; a < 3; a++)
            begin
                dsh = {16'd0, den_in[a]} << (DS - 1 - s);
                q_nx[a] = q_in[a];
                if (rem_in[a] >= dsh)
                begin
                    rem_nx[a] = rem_in[a] - dsh;
                    q_nx[a][DS-1-s] = 1'b1;
                end
                else
                begin
                    rem_nx[a] = rem_in[a];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[s] <= rem_nx;
                dq_reg[s] <= q_nx;
                dden_reg[s] <= den_in;
                dzero_reg[s] <= zero_in;
                droll_reg[s] <= roll_in;
                dpitch_reg[s] <= pitch_in;
            end
        end
    end

    logic signed [15:0] norm_div [3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            norm_div[a] = dzero_reg[DS-1][a] ? 16'sd0 : $signed(dq_reg[DS-1][a] ^ 16'h8000);
        end
    end

    // sine and cosine of both tilt angles
    logic signed [15:0] sin_t;
    logic signed [15:0] cos_t;
    logic signed [15:0] sin_p;
    logic signed [15:0] cos_p;

    mch_sincos u_roll (
        .clk     (clk),
        .en      (en),
        .angle   (droll_reg[DS-1]),
        .sin_q15 (sin_t),
        .cos_q15 (cos_t)
    );

    mch_sincos u_pitch (
        .clk     (clk),
        .en      (en),
        .angle   (dpitch_reg[DS-1]),
        .sin_q15 (sin_p),
        .cos_q15 (cos_p)
    );

    logic signed [15:0] nd_reg [SC+1][3];
    logic               nerr_reg [SC+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg[0] <= norm_div;
            nerr_reg[0] <= |dzero_reg[DS-1];
            for (int j = 1; j <= SC; j++)
            begin
                nd_reg[j] <= nd_reg[j-1];
                nerr_reg[j] <= nerr_reg[j-1];
            end
        end
    end

    // tilt products and sums
    logic signed [31:0] pr_stcp;
    logic signed [31:0] pr_ctsp;
    logic signed [16:0] p1_stcp_reg;
    logic signed [16:0] p1_ctsp_reg;
    logic signed [15:0] p1_st_reg;
    logic signed [15:0] p1_ct_reg;
    logic signed [15:0] p1_cp_reg;
    logic signed [15:0] p1_n_reg [3];
    logic               p1_err_reg;
    logic signed [32:0] p2_m_reg [5];
    logic signed [15:0] p2_n_reg [3];
    logic               p2_err_reg;
    logic signed [VW-1:0] p3_bx_reg;
    logic signed [VW-1:0] p3_by_reg;
    logic signed [15:0] p3_n_reg [3];
    logic               p3_err_reg;

    assign pr_stcp = sin_t * cos_p;
    assign pr_ctsp = cos_t * sin_p;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_stcp_reg <= pr_stcp[31:15];
            p1_ctsp_reg <= pr_ctsp[31:15];
            p1_st_reg <= sin_t;
            p1_ct_reg <= cos_t;
            p1_cp_reg <= cos_p;
            p1_n_reg <= nd_reg[SC];
            p1_err_reg <= nerr_reg[SC];

            p2_m_reg[0] <= p1_n_reg[0] * p1_cp_reg;
            p2_m_reg[1] <= p1_n_reg[1] * p1_stcp_reg;
            p2_m_reg[2] <= p1_n_reg[2] * p1_ctsp_reg;
            p2_m_reg[3] <= p1_n_reg[1] * p1_ct_reg;
            p2_m_reg[4] <= p1_n_reg[2] * p1_st_reg;
            p2_n_reg <= p1_n_reg;
            p2_err_reg <= p1_err_reg;

            p3_bx_reg <= VW'(p2_m_reg[0]) + VW'(p2_m_reg[1]) - VW'(p2_m_reg[2]);
            p3_by_reg <= VW'(p2_m_reg[3]) + VW'(p2_m_reg[4]);
            p3_n_reg <= p2_n_reg;
            p3_err_reg <= p2_err_reg;
        end
    end

    // quarter turn into the right half plane
    logic signed [VW-1:0] pre_x_reg;
    logic signed [VW-1:0] pre_y_reg;
    logic signed [RW-1:0] pre_z_reg;
    logic                 pre_zero_reg;
    logic signed [15:0]   pre_n_reg [3];
    logic                 pre_err_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_zero_reg <= (p3_bx_reg == '0) && (p3_by_reg == '0);
            pre_n_reg <= p3_n_reg;
            pre_err_reg <= p3_err_reg;
            if (p3_bx_reg < 0)
            begin
                if (p3_by_reg >= 0)
                begin
                    pre_x_reg <= p3_by_reg;
                    pre_y_reg <= -p3_bx_reg;
                    pre_z_reg <= mch_pkg::QUARTER_TURN;
                end
                else
                begin
                    pre_x_reg <= -p3_by_reg;
                    pre_y_reg <= p3_bx_reg;
                    pre_z_reg <= -mch_pkg::QUARTER_TURN;
                end
            end
            else
            begin
                pre_x_reg <= p3_bx_reg;
                pre_y_reg <= p3_by_reg;
                pre_z_reg <= '0;
            end
        end
    end

    // vectoring cordic
    logic signed [VW-1:0] vx_reg [SC];
    logic signed [VW-1:0] vy_reg [SC];
    logic signed [RW-1:0] vz_reg [SC];
    logic                 vzero_reg [SC];
    logic signed [15:0]   vn_reg [SC][3];
    logic                 verr_reg [SC];

    for (genvar j = 0; j < SC; j++)
    begin : g_vec
        localparam logic signed [RW-1:0] ARC = $signed({{(RW - 30){1'b0}},
                                                        mch_pkg::ARC_TABLE[j]});
        logic signed [VW-1:0] x_in;
        logic signed [VW-1:0] y_in;
        logic signed [RW-1:0] z_in;
        logic                 zero_in;
        logic signed [15:0]   n_in [3];
        logic                 err_in;
        if (j == 0)
        begin : g_first
            assign x_in = pre_x_reg;
            assign y_in = pre_y_reg;
            assign z_in = pre_z_reg;
            assign zero_in = pre_zero_reg;
            assign n_in = pre_n_reg;
            assign err_in = pre_err_reg;
        end
        else
        begin : g_next
            assign x_in = vx_reg[j-1];
            assign y_in = vy_reg[j-1];
            assign z_in = vz_reg[j-1];
            assign zero_in = vzero_reg[j-1];
            assign n_in = vn_reg[j-1];
            assign err_in = verr_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_in >= 0)
                begin
                    vx_reg[j] <= x_in + (y_in >>> j);
                    vy_reg[j] <= y_in - (x_in >>> j);
                    vz_reg[j] <= z_in + ARC;
                end
                else
                begin
                    vx_reg[j] <= x_in - (y_in >>> j);
                    vy_reg[j] <= y_in + (x_in >>> j);
                    vz_reg[j] <= z_in - ARC;
                end
                vzero_reg[j] <= zero_in;
                vn_reg[j] <= n_in;
                verr_reg[j] <= err_in;
            end
        end
    end

    // binary angle to 1/64 degree
    logic signed [49:0] sc_prod_reg;
    logic               sc_zero_reg;
    logic signed [15:0] sc_n_reg [3];
    logic               sc_err_reg;
    logic signed [50:0] h_sum;
    logic signed [18:0] h_raw;
    logic signed [18:0] h_sat;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_prod_reg <= vz_reg[SC-1] * mch_pkg::HEADING_SCALE;
            sc_zero_reg <= vzero_reg[SC-1];
            sc_n_reg <= vn_reg[SC-1];
            sc_err_reg <= verr_reg[SC-1];
        end
    end

    always_comb
    begin
        h_sum = {sc_prod_reg[49], sc_prod_reg} + 51'sd2147483648;
        h_raw = h_sum[50:32];
        if (sc_zero_reg)
        begin
            h_sat = '0;
        end
        else if (h_raw > mch_pkg::HALF_TURN_LIMIT)
        begin
            h_sat = mch_pkg::HALF_TURN_LIMIT;
        end
        else if (h_raw < -mch_pkg::HALF_TURN_LIMIT)
        begin
            h_sat = -mch_pkg::HALF_TURN_LIMIT;
        end
        else
        begin
            h_sat = h_raw;
        end
    end

    logic signed [15:0] out_nx_reg;
    logic signed [15:0] out_ny_reg;
    logic signed [15:0] out_nz_reg;
    logic signed [14:0] out_head_reg;
    logic               out_err_reg;

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[LAT-1])
        begin
            out_nx_reg <= sc_n_reg[0];
            out_ny_reg <= sc_n_reg[1];
            out_nz_reg <= sc_n_reg[2];
            out_head_reg <= h_sat[14:0];
            out_err_reg <= sc_err_reg;
        end
    end

    assign result.valid = res_vld_reg;
    assign result.norm_x = out_nx_reg;
    assign result.norm_y = out_ny_reg;
    assign result.norm_z = out_nz_reg;
    assign result.heading_angle = out_head_reg;
    assign result.range_error = out_err_reg;

endmodule

FILE: rtl/magnetometer_calibrated_heading.sv
`timescale 1ns / 1ps
// top level of the calibrated tilt-combined compass heading block
// depends on mch_pkg, mch_if, mch_front, mch_queue, mch_back, assert_macros.svh

// Takes one sample per clock when the result side keeps up. Each sample goes
// through a four-item queue, a 16-stage divider (one quotient bit per stage),
// two parallel sine/cosine cordic pipelines of STEP_COUNT stages, three
// multiply/add stages, a quarter-turn stage, a vectoring cordic of STEP_COUNT
// stages, a scale stage and the output register.
// A stalled result holds the whole back pipeline; the queue keeps accepting
// until four items wait. Limit registers reset to the calibration defaults.

`include "assert_macros.svh"

module magnetometer_calibrated_heading (
    input  logic         clk,
    input  logic         rst_n,
    mch_cfg_if.sink      cfg,
    mch_sample_if.sink   sample,
    mch_result_if.source result
);

    mch_pkg::front_item_t f_item;
    mch_pkg::front_item_t q_head;
    logic                 f_push;
    logic                 q_full;
    logic                 q_vld;
    logic                 q_pop;
    logic                 in_acc;
    logic                 head_ok;

    assign in_acc = sample.valid && sample.ready;
    assign head_ok = (result.heading_angle <= 15'sd11520)
                     && (result.heading_angle >= -15'sd11520);

    mch_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .sample  (sample),
        .q_ready (!q_full),
        .push    (f_push),
        .item    (f_item)
    );

    mch_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .wr_item  (f_item),
        .full     (q_full),
        .pop      (q_pop),
        .head_vld (q_vld),
        .head     (q_head)
    );

    mch_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_vld (q_vld),
        .head     (q_head),
        .pop      (q_pop),
        .result   (result)
    );

    `CHK_IMPLY(a_pop_needs_item, clk, rst_n, q_pop, q_vld, "pop from empty queue")
    `CHK_NEXT(a_push_lands, clk, rst_n, in_acc && !q_vld, q_vld, "accepted item missing")
    `CHK_IMPLY(a_heading_range, clk, rst_n, result.valid, head_ok, "heading out of range")

endmodule
